@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ design/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// Types and constants for the spring force accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

  localparam int IDX_W    = 12;
  localparam int COORD_W  = 32;
  localparam int REST_W   = 31;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = 33;   // |d| and |l - l0|
  localparam int PROD_W   = 66;
  localparam int LEN_W    = 34;
  localparam int UNIT_W   = 31;   // unit component, at most 2^30
  localparam int UNIT_SH  = 30;
  localparam int SQ_STEPS = 34;
  localparam int DIV_STEPS = 31;

  localparam int CFG_AW = 3;
  localparam logic CFG_REG_SPRING_CONSTANT = 1'b0;   // word address bit
  localparam logic [31:0] SPRING_CONSTANT_RST = 32'h0001_0000;

  typedef struct packed {
    logic [IDX_W-1:0]          node_index;
    logic signed [COORD_W-1:0] node_x;
    logic signed [COORD_W-1:0] node_y;
    logic signed [COORD_W-1:0] node_z;
    logic signed [COORD_W-1:0] neighbor_x;
    logic signed [COORD_W-1:0] neighbor_y;
    logic signed [COORD_W-1:0] neighbor_z;
    logic [REST_W-1:0]         rest_length;
    logic                      last_neighbor;
  } sfa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_node_index;
    logic signed [SUM_W-1:0] force_x;
    logic signed [SUM_W-1:0] force_y;
    logic signed [SUM_W-1:0] force_z;
    logic                    degenerate;
    logic                    saturated;
  } sfa_out_t;

  typedef enum logic [1:0] {
    RD_HOLD,
    RD_LOAD_SQRT,
    RD_LOAD_DIV,
    RD_STEP
  } rdu_op_t;

  typedef struct packed {
    rdu_op_t            op;
    logic [PROD_W-1:0]  operand;   // radicand, or dividend magnitude in low bits
    logic [LEN_W-1:0]   divisor;
  } rdu_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_MK,
    ST_DIV,
    ST_MU,
    ST_ACC,
    ST_DONE
  } sfa_state_t;

endpackage

`default_nettype wire

@@ design/sfa_rdu.sv @@
// ----------------------------------------------------------------------------
// sfa_rdu
// Root / divide unit: one shared compare-subtract, one bit a cycle on RD_STEP.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_rdu (
  input  wire logic              clk,
  input  wire sfa_pkg::rdu_cmd_t cmd,
  output logic [sfa_pkg::LEN_W-1:0] q
);
  import sfa_pkg::*;

  logic [36:0]      rem_r, rem_nxt;
  logic [LEN_W-1:0] q_r, q_nxt;
  logic [67:0]      sh_r, sh_nxt;
  logic             sq_r, sq_nxt;
  logic [36:0]      sub_a, sub_b;
  logic [37:0]      sub_d;
  logic             ge;

  always_comb begin
    if (sq_r) begin
      sub_a = {rem_r[34:0], sh_r[67:66]};
      sub_b = {1'b0, q_r, 2'b01};
    end else begin
      sub_a = {rem_r[35:0], sh_r[67]};
      sub_b = {3'b000, cmd.divisor};
    end
    sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    ge    = !sub_d[37];

    rem_nxt = rem_r;
    q_nxt   = q_r;
    sh_nxt  = sh_r;
    sq_nxt  = sq_r;
    unique case (cmd.op)
      RD_HOLD: begin
      end
      RD_LOAD_SQRT: begin
        rem_nxt = '0;
        q_nxt   = '0;
        sh_nxt  = {2'b00, cmd.operand};
        sq_nxt  = 1'b1;
      end
      RD_LOAD_DIV: begin
        rem_nxt = 37'(cmd.operand[MAG_W-1:1]);
        q_nxt   = '0;
        sh_nxt  = {cmd.operand[0], 67'd0};
        sq_nxt  = 1'b0;
      end
      RD_STEP: begin
        rem_nxt = ge ? sub_d[36:0] : sub_a;
        q_nxt   = {q_r[LEN_W-2:0], ge};
        sh_nxt  = sq_r ? {sh_r[65:0], 2'b00} : {sh_r[66:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sh_r  <= sh_nxt;
    sq_r  <= sq_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

@@ design/sfa_mul.sv @@
// ----------------------------------------------------------------------------
// sfa_mul
// 33 x 33 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_mul (
  input  wire logic                       clk,
  input  wire logic [sfa_pkg::MAG_W-1:0]  a,
  input  wire logic [sfa_pkg::MAG_W-1:0]  b,
  output logic      [sfa_pkg::PROD_W-1:0] prod
);
  import sfa_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ design/spring_force_accumulator.sv @@
// ----------------------------------------------------------------------------
// spring_force_accumulator
// Hookean spring force summed per node, one spring per item.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_stall    sfa_in_t  (one spring)
//   out_     out  out_valid / out_stall  sfa_out_t (node force, flags)
//   cfg_     in   APB psel/penable       spring_constant at word 0
//
// An item runs from the idle state that takes it through the squares, the
// 34-bit root, k*|l-l0|, per axis the 31-bit quotient, the split product
// and the sum, and the retire state before the next item can be taken.
// Root and quotients share one compare-subtract unit, one bit a cycle.
// Reset clears the sums, flags and handshake state; k returns to 1.0.
// A result waits in the output register; a new item is taken meanwhile,
// and a last item only retires once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_force_accumulator #(
  parameter int NODE_COUNT = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire sfa_pkg::sfa_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output sfa_pkg::sfa_out_t               out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [sfa_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import sfa_pkg::*;

  // m = k*|l-l0| >> FRAC_BITS, split in two halves for the unit product
  localparam int MW  = PROD_W - FRAC_BITS;
  localparam int MLO = (MW + 1) / 2;
  localparam int AW  = MW + UNIT_W;
  localparam int TW  = MW + 1;
  localparam int SW  = ((TW > SUM_W) ? TW : SUM_W) + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  // ---- configuration ----
  logic [31:0] k_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_REG_SPRING_CONSTANT) ? k_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= SPRING_CONSTANT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == CFG_REG_SPRING_CONSTANT) begin
      k_r <= cfg_pwdata;
    end
  end

  // ---- sequencer ----
  sfa_state_t  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic        out_free;
  logic        in_acc;

  // ---- datapath registers ----
  logic [MAG_W-1:0]        mag_r [3];
  logic                    dneg_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic                    zero_seen_r, clip_seen_r;
  logic [IDX_W-1:0]        idx_r;
  logic [REST_W-1:0]       rest_r;
  logic                    last_r;
  logic [PROD_W-1:0]       s_r;
  logic [LEN_W-1:0]        len_r;
  logic                    diff_neg_r;
  logic [MW-1:0]           m_r;
  logic [UNIT_W-1:0]       u_r;
  logic [AW-1:0]           acc_r;
  logic                    out_valid_r;
  sfa_out_t                out_r;

  // shared units
  rdu_cmd_t          rcmd;
  logic [LEN_W-1:0]  rq;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  sfa_rdu u_rdu (.clk(clk), .cmd(rcmd), .q(rq));
  sfa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  logic [1:0]        sel;
  logic [MAG_W-1:0]  mag_sel;
  logic signed [34:0] diff;
  logic [MAG_W-1:0]  dmag;

  // squares select each axis by the step counter, then sel returns to comp_r
  assign sel      = (state_r == ST_SQ && cnt_r != 6'd3) ? cnt_r[1:0] : comp_r;
  assign mag_sel  = mag_r[sel];
  assign diff     = $signed({1'b0, rq}) - $signed({4'd0, rest_r});
  assign dmag     = diff[34] ? MAG_W'(-diff) : MAG_W'(diff);
  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r + 6'd1;
    comp_nxt     = comp_r;
    in_stall     = 1'b1;
    mul_a        = '0;
    mul_b        = '0;
    rcmd.op      = RD_HOLD;
    rcmd.operand = {{(PROD_W-MAG_W){1'b0}}, mag_sel};
    rcmd.divisor = len_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
        if (in_valid) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        mul_a = mag_sel;
        mul_b = mag_sel;
        if (cnt_r == 6'd3) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end
      end
      ST_ROOT: begin
        if (cnt_r == 6'd0) begin
          rcmd.op      = RD_LOAD_SQRT;
          rcmd.operand = s_r;
        end else begin
          rcmd.op = RD_STEP;
        end
        if (cnt_r == 6'(SQ_STEPS)) begin
          state_nxt = ST_MK;
          cnt_nxt   = '0;
        end
      end
      ST_MK: begin
        mul_a = MAG_W'(k_r);
        mul_b = dmag;
        if (cnt_r == 6'd1) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
          comp_nxt  = '0;
        end
      end
      ST_DIV: begin
        rcmd.op = (cnt_r == 6'd0) ? RD_LOAD_DIV : RD_STEP;
        if (cnt_r == 6'(DIV_STEPS)) begin
          state_nxt = ST_MU;
          cnt_nxt   = '0;
        end
      end
      ST_MU: begin
        if (cnt_r == 6'd0) begin
          mul_a = MAG_W'(m_r[MLO-1:0]);
          mul_b = MAG_W'(rq[UNIT_W-1:0]);
        end else begin
          mul_a = MAG_W'(m_r[MW-1:MLO]);
          mul_b = MAG_W'(u_r);
        end
        if (cnt_r == 6'd2) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cnt_nxt = '0;
        if (comp_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
          comp_nxt  = comp_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (!last_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // ---- capture of the spring ----
  logic signed [MAG_W-1:0] d_in [3];

  always_comb begin
    d_in[0] = $signed({in_data.node_x[COORD_W-1], in_data.node_x})
            - $signed({in_data.neighbor_x[COORD_W-1], in_data.neighbor_x});
    d_in[1] = $signed({in_data.node_y[COORD_W-1], in_data.node_y})
            - $signed({in_data.neighbor_y[COORD_W-1], in_data.neighbor_y});
    d_in[2] = $signed({in_data.node_z[COORD_W-1], in_data.node_z})
            - $signed({in_data.neighbor_z[COORD_W-1], in_data.neighbor_z});
  end

  // index reduction, one restoring step per root cycle over the index bits
  logic [3:0]  idx_sh;
  logic [32:0] idx_cmp;
  assign idx_sh  = 4'(4'd11 - cnt_r[3:0]);
  assign idx_cmp = 33'(NODE_COUNT) << idx_sh;

  // ---- per-axis term and saturating sum ----
  logic [TW-1:0]         term_mag;
  logic                  term_neg;
  logic signed [SW-1:0]  tsum;
  logic signed [SUM_W-1:0] sum_new;
  logic                  clip;

  always_comb begin
    term_mag = acc_r[AW-1:UNIT_SH];
    term_neg = (diff_neg_r == dneg_r[comp_r]);
    tsum     = SW'(sum_r[comp_r]) +
               (term_neg ? -$signed(SW'(term_mag)) : $signed(SW'(term_mag)));
    clip     = 1'b0;
    sum_new  = tsum[SUM_W-1:0];
    if (tsum > SAT_HI) begin
      sum_new = SAT_HI[SUM_W-1:0];
      clip    = 1'b1;
    end else if (tsum < SAT_LO) begin
      sum_new = SAT_LO[SUM_W-1:0];
      clip    = 1'b1;
    end
  end

  // payload working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < 3; c++) begin
        dneg_r[c] <= d_in[c][MAG_W-1];
        mag_r[c]  <= d_in[c][MAG_W-1] ? MAG_W'(-d_in[c]) : MAG_W'(d_in[c]);
      end
      idx_r  <= in_data.node_index;
      rest_r <= in_data.rest_length;
      last_r <= in_data.last_neighbor;
      s_r    <= '0;
    end
    if (state_r == ST_SQ && cnt_r != 6'd0) s_r <= s_r + prod;
    if (state_r == ST_ROOT && NODE_COUNT < (1 << IDX_W) && cnt_r < 6'd12 &&
        {21'd0, idx_r} >= idx_cmp) begin
      idx_r <= idx_r - IDX_W'(idx_cmp);
    end
    if (state_r == ST_MK && cnt_r == 6'd0) begin
      len_r      <= rq;
      diff_neg_r <= diff[34];
    end
    if (state_r == ST_MK && cnt_r == 6'd1) m_r <= prod[PROD_W-1:FRAC_BITS];
    if (state_r == ST_MU) begin
      if (cnt_r == 6'd0) u_r <= rq[UNIT_W-1:0];
      else if (cnt_r == 6'd1) acc_r <= AW'(prod);
      else acc_r <= acc_r + (AW'(prod) << MLO);
    end
    if (state_r == ST_DONE && last_r && out_free) begin
      out_r.out_node_index <= idx_r;
      out_r.force_x        <= sum_r[0];
      out_r.force_y        <= sum_r[1];
      out_r.force_z        <= sum_r[2];
      out_r.degenerate     <= zero_seen_r;
      out_r.saturated      <= clip_seen_r;
    end
  end

  // running sums and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
      zero_seen_r <= 1'b0;
      clip_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_MK && cnt_r == 6'd0 && s_r == '0) zero_seen_r <= 1'b1;
      if (state_r == ST_ACC && s_r != '0) begin
        sum_r[comp_r] <= sum_new;
        if (clip) clip_seen_r <= 1'b1;
      end
      if (state_r == ST_DONE && last_r && out_free) begin
        out_valid_r <= 1'b1;
        for (int c = 0; c < 3; c++) sum_r[c] <= '0;
        zero_seen_r <= 1'b0;
        clip_seen_r <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- checks ----
`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_starts, in_acc, state_r == ST_SQ)
  `ASSERT_NEXT(a_result_clears, state_r == ST_DONE && last_r && out_free,
               sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0 && !clip_seen_r)
  `ASSERT_IMPLIES(a_result_source, $rose(out_valid_r),
                  $past(state_r == ST_DONE && last_r))

endmodule

`default_nettype wire
